// ----- hw/rtl/im2c_pkg.sv -----
`default_nettype none

package im2c_pkg;

  // register field widths
  localparam int unsigned CH_REG_W   = 11;
  localparam int unsigned SIDE_REG_W = 9;
  localparam int unsigned K_REG_W    = 4;
  localparam int unsigned S_REG_W    = 4;
  localparam int unsigned P_REG_W    = 3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  // result widths
  localparam int unsigned SRC_W  = 26;
  localparam int unsigned DST_W  = 34;
  localparam int unsigned DCNT_W = 35;

  // (H + 2P - K) fits here for every register value with K <= H + 2P
  localparam int unsigned NUM_W   = 10;
  localparam int unsigned PAD_MAX = 7;
  // common width for bound compares
  localparam int unsigned CMP_W   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CHANNELS = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_IMAGE_WIDTH  = 3'd2,
    CFG_KERNEL_SIZE  = 3'd3,
    CFG_STEP_SIZE    = 3'd4,
    CFG_BORDER_PAD   = 3'd5
  } im2c_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_DIV_H_GO,
    ST_DIV_H,
    ST_DIV_W_GO,
    ST_DIV_W,
    ST_IDLE,
    ST_S1,
    ST_S2,
    ST_S3
  } im2c_state_t;

  typedef struct packed {
    logic div_start;
    logic div_sel_w;
    logic cap_h;
    logic cap_w;
    logic accept;
    logic load_out;
  } im2c_cmd_t;

  typedef struct packed {
    logic div_busy;
  } im2c_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/im2c_divider.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module im2c_divider
  import im2c_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [NUM_W-1:0]   numer,
  input  wire logic [S_REG_W-1:0] denom,
  output logic                    busy,
  output logic [NUM_W-1:0]        quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic [NUM_W-1:0]   num_r;
  logic [S_REG_W-1:0] rem_r;

  logic [S_REG_W:0] trial;
  logic [S_REG_W:0] diff;
  logic             ge;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, denom};
  assign diff  = trial - {1'b0, denom};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // quotient bits shift in as numerator bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[S_REG_W-1:0] : trial[S_REG_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quot = num_r;

endmodule

`default_nettype wire

// ----- hw/rtl/im2c_datapath.sv -----
`default_nettype none

module im2c_datapath
  import im2c_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 1024,
  parameter int unsigned MAX_SIDE     = 256,
  parameter int unsigned MAX_KERNEL   = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_restart,
  input  wire im2c_cmd_t             cmd,
  output im2c_status_t               status,
  output logic [SRC_W-1:0]           out_source_address,
  output logic                       out_is_padding,
  output logic [DST_W-1:0]           out_dest_index,
  output logic                       out_last,
  output logic                       out_bad_config
);

  localparam int unsigned CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned OUT_W    = $clog2(MAX_SIDE + 2 * PAD_MAX);
  localparam int unsigned ROW_W    = OUT_W + S_REG_W + 1;
  localparam int unsigned CHB_W    = SIDE_REG_W + CH_W;
  localparam int unsigned RS_W     = CHB_W + 1;
  localparam int unsigned ADDR_RAW = RS_W + SIDE_REG_W + 1;
  localparam int unsigned ADDR_W   = (ADDR_RAW > SRC_W) ? ADDR_RAW : SRC_W;

  // configuration
  logic [CH_REG_W-1:0]   chans_r;
  logic [SIDE_REG_W-1:0] height_r;
  logic [SIDE_REG_W-1:0] width_r;
  logic [K_REG_W-1:0]    ksize_r;
  logic [S_REG_W-1:0]    step_r;
  logic [P_REG_W-1:0]    pad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chans_r  <= CH_REG_W'(1);
      height_r <= SIDE_REG_W'(1);
      width_r  <= SIDE_REG_W'(1);
      ksize_r  <= K_REG_W'(1);
      step_r   <= S_REG_W'(1);
      pad_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_NUM_CHANNELS: chans_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[SIDE_REG_W-1:0];
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[SIDE_REG_W-1:0];
        CFG_KERNEL_SIZE:  ksize_r  <= cfg_data[K_REG_W-1:0];
        CFG_STEP_SIZE:    step_r   <= cfg_data[S_REG_W-1:0];
        CFG_BORDER_PAD:   pad_r    <= cfg_data[P_REG_W-1:0];
        default: ;
      endcase
    end
  end

  logic cfg_bad;
  always_comb begin
    cfg_bad = (chans_r == '0) || (CMP_W'(chans_r) > CMP_W'(MAX_CHANNELS)) ||
              (height_r == '0) || (CMP_W'(height_r) > CMP_W'(MAX_SIDE)) ||
              (width_r == '0) || (CMP_W'(width_r) > CMP_W'(MAX_SIDE)) ||
              (ksize_r == '0) || (CMP_W'(ksize_r) > CMP_W'(MAX_KERNEL)) ||
              (step_r == '0) ||
              (CMP_W'(ksize_r) > CMP_W'(height_r) + CMP_W'({pad_r, 1'b0})) ||
              (CMP_W'(ksize_r) > CMP_W'(width_r) + CMP_W'({pad_r, 1'b0}));
  end

  // output sizes through the shared divider
  logic [NUM_W-1:0] numer;
  logic [NUM_W-1:0] quot;
  logic [NUM_W-1:0] out_h_r;
  logic [NUM_W-1:0] out_w_r;

  always_comb begin
    if (cmd.div_sel_w) begin
      numer = NUM_W'(width_r) + NUM_W'({pad_r, 1'b0}) - NUM_W'(ksize_r);
    end else begin
      numer = NUM_W'(height_r) + NUM_W'({pad_r, 1'b0}) - NUM_W'(ksize_r);
    end
  end

  im2c_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .numer (numer),
    .denom (step_r),
    .busy  (status.div_busy),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_h) out_h_r <= quot + NUM_W'(1);
    if (cmd.cap_w) out_w_r <= quot + NUM_W'(1);
  end

  // walk position
  logic [CH_W-1:0]    ch_r, ch_nxt, eff_ch;
  logic [K_REG_W-1:0] kr_r, kr_nxt, eff_kr;
  logic [K_REG_W-1:0] kc_r, kc_nxt, eff_kc;
  logic [OUT_W-1:0]   orow_r, orow_nxt, eff_orow;
  logic [OUT_W-1:0]   ocol_r, ocol_nxt, eff_ocol;
  logic [DCNT_W-1:0]  dest_r, dest_nxt, eff_dest;
  logic               done_r, done_nxt, eff_done;
  logic               rewind;
  logic               fin;

  assign rewind   = cfg_bad || in_restart;
  assign eff_ch   = rewind ? '0 : ch_r;
  assign eff_kr   = rewind ? '0 : kr_r;
  assign eff_kc   = rewind ? '0 : kc_r;
  assign eff_orow = rewind ? '0 : orow_r;
  assign eff_ocol = rewind ? '0 : ocol_r;
  assign eff_dest = rewind ? '0 : dest_r;
  assign eff_done = rewind ? 1'b0 : done_r;

  assign fin = (CMP_W'(eff_ch) + CMP_W'(1) >= CMP_W'(chans_r)) &&
               (CMP_W'(eff_kr) + CMP_W'(1) >= CMP_W'(ksize_r)) &&
               (CMP_W'(eff_kc) + CMP_W'(1) >= CMP_W'(ksize_r)) &&
               (CMP_W'(eff_orow) + CMP_W'(1) >= CMP_W'(out_h_r)) &&
               (CMP_W'(eff_ocol) + CMP_W'(1) >= CMP_W'(out_w_r));

  always_comb begin
    ch_nxt   = ch_r;
    kr_nxt   = kr_r;
    kc_nxt   = kc_r;
    orow_nxt = orow_r;
    ocol_nxt = ocol_r;
    dest_nxt = dest_r;
    done_nxt = done_r;
    if (cfg_wr || (cmd.accept && cfg_bad)) begin
      ch_nxt   = '0;
      kr_nxt   = '0;
      kc_nxt   = '0;
      orow_nxt = '0;
      ocol_nxt = '0;
      dest_nxt = '0;
      done_nxt = 1'b0;
    end else if (cmd.accept) begin
      ch_nxt   = eff_ch;
      kr_nxt   = eff_kr;
      kc_nxt   = eff_kc;
      orow_nxt = eff_orow;
      ocol_nxt = eff_ocol;
      dest_nxt = eff_dest;
      done_nxt = eff_done;
      if (!eff_done) begin
        if (fin) begin
          done_nxt = 1'b1;
        end else begin
          dest_nxt = eff_dest + DCNT_W'(1);
          if (CMP_W'(eff_ocol) + CMP_W'(1) < CMP_W'(out_w_r)) begin
            ocol_nxt = eff_ocol + OUT_W'(1);
          end else begin
            ocol_nxt = '0;
            if (CMP_W'(eff_orow) + CMP_W'(1) < CMP_W'(out_h_r)) begin
              orow_nxt = eff_orow + OUT_W'(1);
            end else begin
              orow_nxt = '0;
              if (CMP_W'(eff_kc) + CMP_W'(1) < CMP_W'(ksize_r)) begin
                kc_nxt = eff_kc + K_REG_W'(1);
              end else begin
                kc_nxt = '0;
                if (CMP_W'(eff_kr) + CMP_W'(1) < CMP_W'(ksize_r)) begin
                  kr_nxt = eff_kr + K_REG_W'(1);
                end else begin
                  kr_nxt = '0;
                  ch_nxt = eff_ch + CH_W'(1);
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r   <= '0;
      kr_r   <= '0;
      kc_r   <= '0;
      orow_r <= '0;
      ocol_r <= '0;
      dest_r <= '0;
      done_r <= 1'b0;
    end else begin
      ch_r   <= ch_nxt;
      kr_r   <= kr_nxt;
      kc_r   <= kc_nxt;
      orow_r <= orow_nxt;
      ocol_r <= ocol_nxt;
      dest_r <= dest_nxt;
      done_r <= done_nxt;
    end
  end

  // snapshot of the accepted element
  logic [CH_W-1:0]    ch_s_r;
  logic [K_REG_W-1:0] kr_s_r, kc_s_r;
  logic [OUT_W-1:0]   orow_s_r, ocol_s_r;
  logic [DCNT_W-1:0]  dest_s_r;
  logic               fin_s_r, bad_s_r, zero_s_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_s_r   <= eff_ch;
      kr_s_r   <= eff_kr;
      kc_s_r   <= eff_kc;
      orow_s_r <= eff_orow;
      ocol_s_r <= eff_ocol;
      dest_s_r <= eff_dest;
      fin_s_r  <= fin;
      bad_s_r  <= cfg_bad;
      zero_s_r <= eff_done;
    end
  end

  // stage 1: padded position and channel base
  logic [ROW_W-1:0] rowp_s1_r, colp_s1_r;
  logic [CHB_W-1:0] chb_s1_r;

  always_ff @(posedge clk) begin
    rowp_s1_r <= ROW_W'(kr_s_r) + ROW_W'(orow_s_r) * ROW_W'(step_r);
    colp_s1_r <= ROW_W'(kc_s_r) + ROW_W'(ocol_s_r) * ROW_W'(step_r);
    chb_s1_r  <= CHB_W'(height_r) * CHB_W'(ch_s_r);
  end

  // stage 2: bounds check and row index
  logic [ROW_W-1:0]      row_off, col_off;
  logic                  in_image;
  logic                  in_image_s2_r;
  logic [RS_W-1:0]       rsum_s2_r;
  logic [SIDE_REG_W-1:0] col_s2_r;

  assign row_off  = rowp_s1_r - ROW_W'(pad_r);
  assign col_off  = colp_s1_r - ROW_W'(pad_r);
  assign in_image = (rowp_s1_r >= ROW_W'(pad_r)) && (row_off < ROW_W'(height_r)) &&
                    (colp_s1_r >= ROW_W'(pad_r)) && (col_off < ROW_W'(width_r));

  always_ff @(posedge clk) begin
    in_image_s2_r <= in_image;
    rsum_s2_r     <= RS_W'(chb_s1_r) + RS_W'(row_off[SIDE_REG_W-1:0]);
    col_s2_r      <= col_off[SIDE_REG_W-1:0];
  end

  // stage 3: element address into the result register
  logic [ADDR_W-1:0] addr_full;
  assign addr_full = ADDR_W'(col_s2_r) + ADDR_W'(width_r) * ADDR_W'(rsum_s2_r);

  logic [SRC_W-1:0] src_r;
  logic             pad_flag_r;
  logic [DST_W-1:0] dst_r;
  logic             last_r;
  logic             bad_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      priority if (bad_s_r) begin
        src_r      <= '0;
        pad_flag_r <= 1'b0;
        dst_r      <= '0;
        last_r     <= 1'b0;
        bad_r      <= 1'b1;
      end else if (zero_s_r) begin
        src_r      <= '0;
        pad_flag_r <= 1'b0;
        dst_r      <= '0;
        last_r     <= 1'b0;
        bad_r      <= 1'b0;
      end else begin
        src_r      <= in_image_s2_r ? addr_full[SRC_W-1:0] : '0;
        pad_flag_r <= !in_image_s2_r;
        dst_r      <= dest_s_r[DST_W-1:0];
        last_r     <= fin_s_r;
        bad_r      <= 1'b0;
      end
    end
  end

  assign out_source_address = src_r;
  assign out_is_padding     = pad_flag_r;
  assign out_dest_index     = dst_r;
  assign out_last           = last_r;
  assign out_bad_config     = bad_r;

endmodule

`default_nettype wire

// ----- hw/rtl/im2c_ctrl.sv -----
`default_nettype none

module im2c_ctrl
  import im2c_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         out_stall,
  output logic              out_valid,
  input  wire im2c_status_t status,
  output im2c_cmd_t         cmd
);

  im2c_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    if (cfg_wr) begin
      state_nxt = ST_DIV_H_GO;
    end else begin
      unique case (state_r)
        ST_DIV_H_GO: state_nxt = ST_DIV_H;
        ST_DIV_H:    if (!status.div_busy) state_nxt = ST_DIV_W_GO;
        ST_DIV_W_GO: state_nxt = ST_DIV_W;
        ST_DIV_W:    if (!status.div_busy) state_nxt = ST_IDLE;
        ST_IDLE:     if (in_valid) state_nxt = ST_S1;
        ST_S1:       state_nxt = ST_S2;
        ST_S2:       state_nxt = ST_S3;
        ST_S3:       if (out_free) state_nxt = ST_IDLE;
        default:     state_nxt = ST_DIV_H_GO;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    in_stall      = (state_r != ST_IDLE);
    cmd.div_start = (state_r == ST_DIV_H_GO) || (state_r == ST_DIV_W_GO);
    cmd.div_sel_w = (state_r == ST_DIV_W_GO) || (state_r == ST_DIV_W);
    cmd.cap_h     = (state_r == ST_DIV_H) && !status.div_busy;
    cmd.cap_w     = (state_r == ST_DIV_W) && !status.div_busy;
    cmd.accept    = (state_r == ST_IDLE) && in_valid;
    cmd.load_out  = (state_r == ST_S3) && out_free;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_DIV_H_GO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_cfg_restarts_sizing: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> state_r == ST_DIV_H_GO)
    else $error("config write did not restart output size computation");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !status.div_busy)
    else $error("divider busy while accepting items");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !cfg_wr) |=> state_r == ST_S1)
    else $error("accepted item did not enter first stage");

  a_result_from_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_S3)
    else $error("result raised outside the output stage");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/im2col_address_generator_unit.sv -----
`default_nettype none

// Channel  Ports                                   Transfer when
// -------  --------------------------------------  ------------------------
// in       in_valid, in_stall, in_restart           in_valid && !in_stall
// out      out_valid, out_stall, out_source_address, out_valid && !out_stall
//          out_is_padding, out_dest_index,
//          out_last, out_bad_config
// cfg      cfg_valid, cfg_ready, cfg_index,         cfg_valid && cfg_ready
//          cfg_data
//
// After its input transfer each item is snapshotted, then passes the stages for
// padded position and channel base, bounds check and row index, then width
// times row into the output register. in_stall stays high while the item is in
// those stages, so the next item is accepted only once the last one is loaded.
// After reset and after every config write the output sizes are computed by
// one shared restoring divider, height then width, with in_stall high.
// A result waits in the output register under out_stall; the next item is
// accepted meanwhile and holds in the last stage until the register frees.
// cfg_ready is always high; any write rewinds the walk to its first element.
module im2col_address_generator_unit
  import im2c_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 1024,
  parameter int unsigned MAX_SIDE     = 256,
  parameter int unsigned MAX_KERNEL   = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_restart,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [SRC_W-1:0]           out_source_address,
  output logic                       out_is_padding,
  output logic [DST_W-1:0]           out_dest_index,
  output logic                       out_last,
  output logic                       out_bad_config,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  im2c_cmd_t    cmd;
  im2c_status_t status;
  logic         cfg_wr;

  // the user must make writes only while idle; the block does not enforce it and has no back-pressure
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // sequencing: output sizing, accept, three compute stages, result load
  im2c_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  // registers, walk counters, divider and address pipeline
  im2c_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_SIDE     (MAX_SIDE),
    .MAX_KERNEL   (MAX_KERNEL)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr             (cfg_wr),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_restart         (in_restart),
    .cmd                (cmd),
    .status             (status),
    .out_source_address (out_source_address),
    .out_is_padding     (out_is_padding),
    .out_dest_index     (out_dest_index),
    .out_last           (out_last),
    .out_bad_config     (out_bad_config)
  );

endmodule

`default_nettype wire
